### hw/rtl/mvra_pkg.sv
// Shared types, codes and constants of the MSI vector region allocator.
`default_nettype none

package mvra_pkg;

  // Operation codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_SPACE  = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MSI_MAP_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MSI_MAP_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MSIX_BASE    = 2'd2;

  // Configuration reset values
  localparam logic [31:0] MSI_MAP_LOW_RST  = 32'h6D6C_6B6A;
  localparam logic [31:0] MSI_MAP_HIGH_RST = 32'h918F_8D8B;
  localparam logic [9:0]  MSIX_BASE_RST    = 10'd185;

  // Interrupt number offset added to MSI table entries
  localparam logic [9:0] SPI_OFFSET = 10'd32;

  // Region order: log2 of the rounded vector count, 0..6
  localparam int unsigned ORDER_W = 3;

  typedef struct packed {
    logic       cmd;
    logic       is_msix;
    logic [5:0] vector_count;
    logic [9:0] free_vector;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] vector;
  } rsp_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ctrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // latch the request
    logic exec;  // search, update maps, register result
  } dp_cmd_t;

  // Round a count up to the next power of two, return the exponent.
  function automatic logic [ORDER_W-1:0] count_order(input logic [5:0] cnt);
    logic [ORDER_W-1:0] k;
    if (cnt <= 6'd1)       k = 3'd0;
    else if (cnt <= 6'd2)  k = 3'd1;
    else if (cnt <= 6'd4)  k = 3'd2;
    else if (cnt <= 6'd8)  k = 3'd3;
    else if (cnt <= 6'd16) k = 3'd4;
    else if (cnt <= 6'd32) k = 3'd5;
    else                   k = 3'd6;
    return k;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/msi_vector_region_allocator.sv
// Top level of the MSI / MSI-X vector region allocator.
// An accepted item is latched into the request register; the execute state registers its result and strobes done_o.
// A new item is not taken while one executes; busy is high for the single execute cycle.
// The execute cycle runs the aligned region search over the whole pool map in parallel.
// Reset: both used maps clear to all free, config registers load their defaults.
// The result is strobed on done_o for exactly one cycle; the receiver cannot stall it.
`default_nettype none

module msi_vector_region_allocator #(
  parameter int unsigned MSI_ENTRIES  = 8,   // 1..8
  parameter int unsigned MSIX_ENTRIES = 32   // 1..64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // request channel
  input  wire logic                            start,
  output logic                                 busy,
  input  wire mvra_pkg::req_t                  req_i,
  // result channel
  output logic                                 done_o,
  output mvra_pkg::rsp_t                       rsp_o,
  // configuration write channel
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [mvra_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [31:0]                     cfg_data_i
);
  import mvra_pkg::*;

  dp_cmd_t dp_cmd;

  // config writes go straight into the config registers, always accepted
  assign cfg_ready_o = 1'b1;

  mvra_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .done_o   (done_o),
    .dp_cmd_o (dp_cmd)
  );

  mvra_datapath #(
    .MSI_ENTRIES  (MSI_ENTRIES),
    .MSIX_ENTRIES (MSIX_ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .req_i       (req_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rsp_o       (rsp_o)
  );

  // result strobe only while idle, so a new item can be taken alongside it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // an accepted item makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not start");

  // failed or free results carry no vector
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status != STATUS_OK) |-> (rsp_o.vector == '0))
    else $error("nonzero vector on failed request");

  // single-cycle strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire

### hw/rtl/mvra_pool.sv
// One used-bit pool: aligned free region search, region set and clear.
`default_nettype none

module mvra_pool #(
  parameter int unsigned ENTRIES = 8,
  parameter int unsigned PW      = 3
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [mvra_pkg::ORDER_W-1:0]  order_i,
  input  wire logic                          alloc_i,
  input  wire logic                          free_i,
  input  wire logic [PW-1:0]                 free_pos_i,
  output logic                               found_o,
  output logic [PW-1:0]                      pos_o
);
  import mvra_pkg::*;

  localparam int unsigned NUM_LVL = 2 ** ORDER_W;

  logic [ENTRIES-1:0] used_q, used_d;
  logic [ENTRIES-1:0] lvl [NUM_LVL];
  logic [ENTRIES-1:0] cand;
  logic [ENTRIES-1:0] mask;
  logic [PW-1:0]      sel_pos;

  // lvl[l][p]: the 2^l entries from p upward exist and are all free
  always_comb begin
    lvl[0] = ~used_q;
    for (int l = 1; l < NUM_LVL; l++) begin
      for (int p = 0; p < ENTRIES; p++) begin
        lvl[l][p] = 1'b0;
        if (p + (1 << (l - 1)) < ENTRIES) begin
          lvl[l][p] = lvl[l-1][p] & lvl[l-1][p + (1 << (l - 1))];
        end
      end
    end
  end

  // candidates are aligned to the region size; lowest wins
  always_comb begin
    found_o = 1'b0;
    pos_o   = '0;
    for (int p = 0; p < ENTRIES; p++) begin
      cand[p] = lvl[order_i][p] && ((p & ((1 << order_i) - 1)) == 0);
    end
    for (int p = ENTRIES - 1; p >= 0; p--) begin
      if (cand[p]) begin
        found_o = 1'b1;
        pos_o   = PW'(p);
      end
    end
  end

  // region mask from the selected start, cut at the pool's end
  always_comb begin
    sel_pos = alloc_i ? pos_o : free_pos_i;
    for (int j = 0; j < ENTRIES; j++) begin
      mask[j] = (j >= int'(sel_pos)) && ((j - int'(sel_pos)) < (1 << order_i));
    end
  end

  always_comb begin
    used_d = used_q;
    if (alloc_i && found_o) begin
      used_d = used_q | mask;
    end else if (free_i) begin
      used_d = used_q & ~mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  // a successful allocation marks its start entry used
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    alloc_i && found_o |=> used_q[$past(pos_o)])
    else $error("allocated region start not marked used");

  // a found region was free before the allocation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    alloc_i && found_o |-> !used_q[pos_o])
    else $error("allocation picked a used entry");

  // nothing changes while the pool is not addressed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !alloc_i && !free_i |=> $stable(used_q))
    else $error("pool map changed without a command");

endmodule

`default_nettype wire

### hw/rtl/mvra_datapath.sv
// Datapath: request latch, config registers, both pools, lookup and result.
`default_nettype none

module mvra_datapath #(
  parameter int unsigned MSI_ENTRIES  = 8,
  parameter int unsigned MSIX_ENTRIES = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire mvra_pkg::dp_cmd_t                cmd_i,
  input  wire mvra_pkg::req_t                   req_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [mvra_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [31:0]                      cfg_data_i,
  output mvra_pkg::rsp_t                        rsp_o
);
  import mvra_pkg::*;

  localparam int unsigned PWM = (MSI_ENTRIES > 1)  ? $clog2(MSI_ENTRIES)  : 1;
  localparam int unsigned PWX = (MSIX_ENTRIES > 1) ? $clog2(MSIX_ENTRIES) : 1;
  localparam logic [9:0]  NUM_MSIX = 10'(MSIX_ENTRIES);

  // config registers
  logic [31:0] map_low_q, map_high_q;
  logic [9:0]  msix_base_q;

  // latched request
  logic               cmd_q, is_msix_q;
  logic [ORDER_W-1:0] order_q;
  logic [9:0]         fv_q;

  rsp_t rsp_q, rsp_d;

  logic [63:0]        tbl;
  logic [7:0]         irq [MSI_ENTRIES];
  logic               msi_hit, msix_hit;
  logic [PWM-1:0]     msi_hit_pos;
  logic [10:0]        diff;
  logic               msi_alloc, msi_free, msix_alloc, msix_free;
  logic               msi_found, msix_found;
  logic [PWM-1:0]     msi_pos;
  logic [PWX-1:0]     msix_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_low_q   <= MSI_MAP_LOW_RST;
      map_high_q  <= MSI_MAP_HIGH_RST;
      msix_base_q <= MSIX_BASE_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_MSI_MAP_LOW)  map_low_q   <= cfg_data_i;
      if (cfg_index_i == CFG_MSI_MAP_HIGH) map_high_q  <= cfg_data_i;
      if (cfg_index_i == CFG_MSIX_BASE)    msix_base_q <= cfg_data_i[9:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q     <= req_i.cmd;
      is_msix_q <= req_i.is_msix;
      order_q   <= count_order(req_i.vector_count);
      fv_q      <= req_i.free_vector;
    end
  end

  // MSI table lookup: first matching entry wins
  always_comb begin
    tbl         = {map_high_q, map_low_q};
    msi_hit     = 1'b0;
    msi_hit_pos = '0;
    for (int i = 0; i < MSI_ENTRIES; i++) begin
      irq[i] = tbl[8*i +: 8];
    end
    for (int i = MSI_ENTRIES - 1; i >= 0; i--) begin
      if ({2'b00, irq[i]} + SPI_OFFSET == fv_q) begin
        msi_hit     = 1'b1;
        msi_hit_pos = PWM'(i);
      end
    end
  end

  // MSI-X range check, no wrap on the compare
  assign diff     = {1'b0, fv_q} - {1'b0, msix_base_q};
  assign msix_hit = !diff[10] && (diff[9:0] < NUM_MSIX);

  assign msi_alloc  = cmd_i.exec && (cmd_q == CMD_ALLOC) && !is_msix_q;
  assign msix_alloc = cmd_i.exec && (cmd_q == CMD_ALLOC) && is_msix_q;
  assign msi_free   = cmd_i.exec && (cmd_q == CMD_FREE) && msi_hit;
  assign msix_free  = cmd_i.exec && (cmd_q == CMD_FREE) && !msi_hit && msix_hit;

  mvra_pool #(
    .ENTRIES (MSI_ENTRIES),
    .PW      (PWM)
  ) u_msi_pool (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .order_i    (order_q),
    .alloc_i    (msi_alloc),
    .free_i     (msi_free),
    .free_pos_i (msi_hit_pos),
    .found_o    (msi_found),
    .pos_o      (msi_pos)
  );

  mvra_pool #(
    .ENTRIES (MSIX_ENTRIES),
    .PW      (PWX)
  ) u_msix_pool (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .order_i    (order_q),
    .alloc_i    (msix_alloc),
    .free_i     (msix_free),
    .free_pos_i (diff[PWX-1:0]),
    .found_o    (msix_found),
    .pos_o      (msix_pos)
  );

  always_comb begin
    rsp_d.status = STATUS_OK;
    rsp_d.vector = '0;
    if (cmd_q == CMD_ALLOC) begin
      if (is_msix_q) begin
        if (msix_found) rsp_d.vector = msix_base_q + 10'(msix_pos);
        else            rsp_d.status = STATUS_NO_SPACE;
      end else begin
        if (msi_found) rsp_d.vector = {2'b00, irq[msi_pos]} + SPI_OFFSET;
        else           rsp_d.status = STATUS_NO_SPACE;
      end
    end else if (!msi_hit && !msix_hit) begin
      rsp_d.status = STATUS_NOT_FOUND;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

### hw/rtl/mvra_ctrl.sv
// Controller: request sequencing and the result strobe.
`default_nettype none

module mvra_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start,
  output logic              busy,
  output logic              done_o,
  output mvra_pkg::dp_cmd_t dp_cmd_o
);
  import mvra_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    dp_cmd_o.load = 1'b0;
    dp_cmd_o.exec = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          dp_cmd_o.load = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        dp_cmd_o.exec = 1'b1;
        state_d       = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    done_d = dp_cmd_o.exec;
  end

  assign busy   = (state_q == ST_EXEC);
  assign done_o = done_q;

  // load and exec never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dp_cmd_o.load && dp_cmd_o.exec))
    else $error("load and exec in the same cycle");

  // a loaded item executes in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_o.load |=> dp_cmd_o.exec)
    else $error("loaded item not executed");

  // the strobe follows execution exactly
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_o.exec |=> done_o)
    else $error("missing result strobe");

endmodule

`default_nettype wire

### dv/tb_msi_vector_region_allocator.sv
// Self-checking testbench of the MSI / MSI-X vector region allocator.
`default_nettype none

module tb_msi_vector_region_allocator;
  import mvra_pkg::*;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // DUT ports; the inputs are at known values from time zero
  logic                 start       = 1'b0;
  logic                 busy;
  req_t                 req_i       = '0;
  logic                 done_o;
  rsp_t                 rsp_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0]          cfg_data_i  = '0;

  msi_vector_region_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  localparam int MSI_POOL     = 8;
  localparam int MSIX_POOL    = 32;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 230;
  localparam int CALM_ITEMS   = 150;   // tail of the run with no sender gaps
  localparam int STALL_LIMIT  = 1000;  // cycles with no handshake at all

  // Directed rows. Where typed is set the expected result is taken from the row,
  // otherwise from the predictor. All rows assume the reset configuration:
  // MSI entries map to vectors 138 139 140 141 171 173 175 177, MSI-X base 185.
  typedef struct packed {
    logic       cmd;
    logic       is_msix;
    logic [5:0] cnt;
    logic [9:0] fv;
    logic       typed;
    logic [1:0] st;
    logic [9:0] vec;
  } plan_row_t;

  localparam plan_row_t DIRECTED_PLAN [24] = '{
    // zero count is taken as one: entry 0
    '{CMD_ALLOC, 1'b0, 6'd0,  10'h3FF, 1'b1, STATUS_OK,        10'd138},
    // three rounds up to four; first aligned quad with entry 0 taken is entry 4
    '{CMD_ALLOC, 1'b0, 6'd3,  10'd0,   1'b1, STATUS_OK,        10'd171},
    // region bigger than the MSI pool
    '{CMD_ALLOC, 1'b0, 6'd9,  10'd0,   1'b1, STATUS_NO_SPACE,  10'd0},
    '{CMD_ALLOC, 1'b0, 6'd2,  10'd0,   1'b0, STATUS_OK,        10'd0},
    '{CMD_ALLOC, 1'b0, 6'd1,  10'd0,   1'b0, STATUS_OK,        10'd0},
    // MSI pool now full
    '{CMD_ALLOC, 1'b0, 6'd1,  10'd0,   1'b1, STATUS_NO_SPACE,  10'd0},
    '{CMD_FREE,  1'b0, 6'd4,  10'd171, 1'b1, STATUS_OK,        10'd0},
    // oversized free: bits past the end of the pool drop out
    '{CMD_FREE,  1'b1, 6'd63, 10'd140, 1'b1, STATUS_OK,        10'd0},
    '{CMD_FREE,  1'b0, 6'd1,  10'd0,   1'b1, STATUS_NOT_FOUND, 10'd0},
    '{CMD_FREE,  1'b1, 6'd32, 10'h3FF, 1'b1, STATUS_NOT_FOUND, 10'd0},
    '{CMD_ALLOC, 1'b1, 6'd32, 10'h3FF, 1'b1, STATUS_OK,        10'd185},
    '{CMD_ALLOC, 1'b1, 6'd1,  10'd0,   1'b1, STATUS_NO_SPACE,  10'd0},
    '{CMD_ALLOC, 1'b1, 6'd63, 10'd0,   1'b1, STATUS_NO_SPACE,  10'd0},
    // free with pool select of MSI still lands in MSI-X: last entry
    '{CMD_FREE,  1'b0, 6'd1,  10'd216, 1'b1, STATUS_OK,        10'd0},
    '{CMD_ALLOC, 1'b1, 6'd1,  10'd0,   1'b0, STATUS_OK,        10'd0},
    '{CMD_FREE,  1'b0, 6'd32, 10'd185, 1'b1, STATUS_OK,        10'd0},
    '{CMD_ALLOC, 1'b1, 6'd17, 10'd0,   1'b0, STATUS_OK,        10'd0},
    '{CMD_FREE,  1'b1, 6'd32, 10'd185, 1'b1, STATUS_OK,        10'd0},
    '{CMD_FREE,  1'b0, 6'd1,  10'd139, 1'b1, STATUS_OK,        10'd0},
    '{CMD_FREE,  1'b0, 6'd1,  10'd138, 1'b1, STATUS_OK,        10'd0},
    // freeing an entry that is already free still succeeds
    '{CMD_FREE,  1'b0, 6'd1,  10'd138, 1'b1, STATUS_OK,        10'd0},
    '{CMD_ALLOC, 1'b0, 6'd8,  10'd0,   1'b0, STATUS_OK,        10'd0},
    '{CMD_FREE,  1'b1, 6'd8,  10'd138, 1'b1, STATUS_OK,        10'd0},
    '{CMD_ALLOC, 1'b0, 6'd63, 10'h3FF, 1'b1, STATUS_NO_SPACE,  10'd0}
  };

  // Predictor state: configuration and the two used maps
  logic [31:0]          msi_map_lo;
  logic [31:0]          msi_map_hi;
  logic [9:0]           msix_first;
  logic [MSI_POOL-1:0]  msi_taken;
  logic [MSIX_POOL-1:0] msix_taken;

  typedef struct {
    logic [9:0] vec;
    logic [5:0] cnt;
  } grant_t;

  rsp_t   pending_rsp [$];   // results still owed by the DUT, oldest first
  grant_t granted     [$];   // live allocations, used to aim frees
  int     errors = 0;
  int     quiet_cycles = 0;

  function automatic logic [7:0] msi_irq(int i);
    return (i < 4) ? msi_map_lo[8*i +: 8] : msi_map_hi[8*(i-4) +: 8];
  endfunction

  function automatic logic [63:0] span_mask(int sz, int at);
    logic [63:0] ones;
    ones = (sz >= 64) ? {64{1'b1}} : ((64'd1 << sz) - 64'd1);
    return ones << at;
  endfunction

  // Works out the result of one request and updates the used maps.
  function automatic rsp_t grant_or_release(req_t r);
    rsp_t        o;
    int          ord;
    int          sz;
    bit          hit;
    logic [63:0] m;
    o.status = STATUS_OK;
    o.vector = '0;
    hit      = 1'b0;
    ord      = 0;
    while (ord < 6 && (1 << ord) < int'(r.vector_count)) ord++;
    sz = 1 << ord;
    if (r.cmd == CMD_ALLOC) begin
      if (r.is_msix) begin
        for (int p = 0; p + sz <= MSIX_POOL; p += sz) begin
          m = span_mask(sz, p);
          if (!hit && (msix_taken & m[MSIX_POOL-1:0]) == '0) begin
            msix_taken |= m[MSIX_POOL-1:0];
            o.vector   = msix_first + 10'(p);   // wraps at 10 bits
            hit        = 1'b1;
          end
        end
      end else begin
        for (int p = 0; p + sz <= MSI_POOL; p += sz) begin
          m = span_mask(sz, p);
          if (!hit && (msi_taken & m[MSI_POOL-1:0]) == '0) begin
            msi_taken |= m[MSI_POOL-1:0];
            o.vector  = {2'b00, msi_irq(p)} + SPI_OFFSET;
            hit       = 1'b1;
          end
        end
      end
      if (!hit) o.status = STATUS_NO_SPACE;
    end else begin
      // MSI table first, lowest entry wins
      for (int i = 0; i < MSI_POOL; i++) begin
        if (!hit && int'(msi_irq(i)) + int'(SPI_OFFSET) == int'(r.free_vector)) begin
          m         = span_mask(sz, i);
          msi_taken &= ~m[MSI_POOL-1:0];
          hit       = 1'b1;
        end
      end
      // MSI-X range does not wrap: base plus position past 1023 never matches
      for (int i = 0; i < MSIX_POOL; i++) begin
        if (!hit && int'(msix_first) + i == int'(r.free_vector)) begin
          m          = span_mask(sz, i);
          msix_taken &= ~m[MSIX_POOL-1:0];
          hit        = 1'b1;
        end
      end
      if (!hit) o.status = STATUS_NOT_FOUND;
    end
    return o;
  endfunction

  // Mostly small counts, now and then anything the field holds
  function automatic logic [5:0] pick_count();
    return ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                       : 6'($urandom_range(1, 8));
  endfunction

  // Holds start high until the item is taken; start stays high on return.
  task automatic issue(input req_t r, input bit typed, input rsp_t want);
    rsp_t got;
    grant_t g;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    got = grant_or_release(r);
    pending_rsp.push_back(typed ? want : got);
    if (r.cmd == CMD_ALLOC && got.status == STATUS_OK) begin
      g.vec = got.vector;
      g.cnt = r.vector_count;
      granted.push_back(g);
    end
  endtask

  // Leaves cfg_valid_i high; the caller drops it after the last write.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MSI_MAP_LOW:  msi_map_lo = data;
      CFG_MSI_MAP_HIGH: msi_map_hi = data;
      CFG_MSIX_BASE:    msix_first = data[9:0];
      default: ;   // unknown index is ignored
    endcase
  endtask

  task automatic drain_results();
    @(posedge clk_i);
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  // Random request: allocations, frees aimed at live regions or pool entries,
  // and stray frees.
  function automatic req_t random_request();
    req_t   r;
    int     pick;
    int     idx;
    grant_t g;
    r.cmd          = CMD_ALLOC;
    r.is_msix      = 1'($urandom_range(0, 1));
    r.vector_count = pick_count();
    r.free_vector  = 10'($urandom_range(0, 1023));
    pick           = $urandom_range(0, 99);
    if (pick >= 45) begin
      r.cmd = CMD_FREE;
      if (pick < 75 && granted.size() != 0) begin
        idx = $urandom_range(0, granted.size() - 1);
        g   = granted[idx];
        granted.delete(idx);
        r.free_vector = g.vec;
        if ($urandom_range(0, 3) != 0) r.vector_count = g.cnt;
      end else if (pick < 92) begin
        if ($urandom_range(0, 1) == 1)
          r.free_vector = {2'b00, msi_irq($urandom_range(0, MSI_POOL - 1))} + SPI_OFFSET;
        else
          r.free_vector = msix_first + 10'($urandom_range(0, MSIX_POOL - 1));
      end
    end
    return r;
  endfunction

  // Result checker and watchdog
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_rsp.size() == 0) begin
          $display("%0t: result with nothing pending: status %0d vector %0d",
                   $time, rsp_o.status, rsp_o.vector);
          errors++;
        end else begin
          want = pending_rsp.pop_front();
          if (rsp_o.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_o.status);
            errors++;
          end
          if (rsp_o.vector !== want.vector) begin
            $display("%0t: vector expected %0d, got %0d", $time, want.vector, rsp_o.vector);
            errors++;
          end
        end
      end
      if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    req_t      r;
    rsp_t      want;
    plan_row_t row;
    int        sent;
    msi_map_lo = MSI_MAP_LOW_RST;
    msi_map_hi = MSI_MAP_HIGH_RST;
    msix_first = MSIX_BASE_RST;
    msi_taken  = '0;
    msix_taken = '0;
    sent       = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset configuration
    foreach (DIRECTED_PLAN[i]) begin
      row            = DIRECTED_PLAN[i];
      r.cmd          = row.cmd;
      r.is_msix      = row.is_msix;
      r.vector_count = row.cnt;
      r.free_vector  = row.fv;
      want.status    = row.st;
      want.vector    = row.vec;
      issue(r, row.typed, want);
    end

    // Random part, one configuration per phase. Registers change only with
    // the block idle and every owed result in.
    for (int ph = 0; ph < PHASES; ph++) begin
      start <= 1'b0;
      drain_results();
      case (ph)
        0: begin   // every entry the same irq, MSI-X range covers the MSI vectors
          cfg_write(CFG_MSI_MAP_LOW, 32'h0);
          cfg_write(CFG_MSI_MAP_HIGH, 32'h0);
          cfg_write(CFG_MSIX_BASE, 32'd16);
        end
        1: begin   // highest irq, MSI-X vectors wrap past 1023
          cfg_write(CFG_MSI_MAP_LOW, 32'hFFFF_FFFF);
          cfg_write(CFG_MSI_MAP_HIGH, 32'hFFFF_FFFF);
          cfg_write(CFG_MSIX_BASE, 32'd1023);
        end
        2: begin
          cfg_write(CFG_MSI_MAP_LOW, $urandom);
          cfg_write(CFG_MSI_MAP_HIGH, $urandom);
          cfg_write(CFG_MSIX_BASE, 32'd992);
        end
        3: begin
          cfg_write(CFG_MSI_MAP_LOW, $urandom);
          cfg_write(CFG_MSI_MAP_HIGH, $urandom);
          cfg_write(CFG_MSIX_BASE, 32'd0);
        end
        4: begin   // MSI-X range overlaps the MSI vectors; MSI must win frees
          cfg_write(CFG_MSI_MAP_LOW, MSI_MAP_LOW_RST);
          cfg_write(CFG_MSI_MAP_HIGH, MSI_MAP_HIGH_RST);
          cfg_write(CFG_MSIX_BASE, 32'd120);
        end
        default: begin
          cfg_write(CFG_MSI_MAP_LOW, $urandom);
          cfg_write(CFG_MSI_MAP_HIGH, $urandom);
          cfg_write(CFG_MSIX_BASE, $urandom);
        end
      endcase
      cfg_write(2'd3, $urandom);   // unused index, must have no effect
      cfg_valid_i <= 1'b0;
      granted.delete();

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        issue(random_request(), 1'b0, want);
        sent++;
        if (sent < PHASES * PHASE_ITEMS - CALM_ITEMS && $urandom_range(0, 7) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 16)) @(posedge clk_i);
        end
      end
    end

    start <= 1'b0;
    drain_results();
    repeat (8) @(posedge clk_i);   // catch any stray result
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
hw/rtl/mvra_pkg.sv
hw/rtl/mvra_pool.sv
hw/rtl/mvra_datapath.sv
hw/rtl/mvra_ctrl.sv
hw/rtl/msi_vector_region_allocator.sv
dv/tb_msi_vector_region_allocator.sv
